[hw/rtl/pbfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pbfp_pkg;

  // Frame buffer length; positions run 0..MAX_FRAME_LEN, the top value means idle.
  localparam int MAX_FRAME_LEN = 32;
  localparam int POS_W         = $clog2(MAX_FRAME_LEN + 1);
  localparam int ADDR_W        = $clog2(MAX_FRAME_LEN);

  // Job queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_CODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_CODE = CFG_IDX_W'(1);

  localparam logic [7:0] LED_CODE_RST  = 8'd80;
  localparam logic [7:0] TEXT_CODE_RST = 8'd76;

  localparam logic [POS_W-1:0] POS_IDLE = POS_W'(MAX_FRAME_LEN);

  // Result kinds as seen on the output.
  localparam logic MSG_LED  = 1'b0;
  localparam logic MSG_TEXT = 1'b1;

  typedef enum logic {
    JOB_LED,
    JOB_TEXT
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] led_word;
    logic [7:0]  len;
  } job_t;

  typedef struct packed {
    logic        msg_kind;
    logic [15:0] led_word;
    logic [7:0]  text_byte;
    logic        text_valid;
    logic        last_of_frame;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

[hw/rtl/pbfp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module pbfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pbfp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module pbfp_front
  import pbfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              start_mark,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [7:0]        led_code,
  input  wire logic [7:0]        text_code,
  input  wire logic              q_full,
  output logic                   push,
  output job_t                   push_job,
  input  wire logic              text_done,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [7:0]             ram_wdata
);

  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       sum, sum_next;
  logic [7:0]       cmd, cmd_next;
  logic [7:0]       d1, d1_next;
  logic [7:0]       d2, d2_next;
  logic             text_busy, text_busy_next;

  logic             accept;
  logic [8:0]       pos_ext;
  logic [8:0]       text_end;

  assign in_ready  = !q_full && !text_busy;
  assign accept    = in_valid && in_ready;
  assign pos_ext   = 9'(pos);
  assign text_end  = {1'b0, d1} + 9'd2;
  assign ram_waddr = pos[ADDR_W-1:0];
  assign ram_wdata = rx_byte;

  always_comb begin
    pos_next          = pos;
    sum_next          = sum;
    cmd_next          = cmd;
    d1_next           = d1;
    d2_next           = d2;
    push              = 1'b0;
    push_job.kind     = JOB_LED;
    push_job.led_word = {d2, d1};
    push_job.len      = d1;
    ram_we            = 1'b0;

    if (accept) begin
      if (start_mark) begin
        cmd_next = rx_byte;
        sum_next = rx_byte;
        pos_next = POS_W'(1);
      end else if (pos != POS_IDLE) begin
        if (cmd == led_code) begin
          if (pos < POS_W'(3)) begin
            if (pos == POS_W'(1)) begin
              d1_next = rx_byte;
            end else begin
              d2_next = rx_byte;
            end
            sum_next = sum + rx_byte;
            pos_next = pos + POS_W'(1);
          end else if (pos == POS_W'(3)) begin
            push          = (sum == rx_byte);
            push_job.kind = JOB_LED;
            pos_next      = pos + POS_W'(1);
          end
        end else if (cmd == text_code) begin
          if (pos == POS_W'(1) || pos_ext < text_end) begin
            if (pos == POS_W'(1)) begin
              d1_next = rx_byte;
            end
            ram_we   = 1'b1;
            sum_next = sum + rx_byte;
            pos_next = pos + POS_W'(1);
          end else if (pos_ext == text_end) begin
            push          = (sum == rx_byte);
            push_job.kind = JOB_TEXT;
            pos_next      = pos + POS_W'(1);
          end
        end
      end
    end

    // Hold input off while a text burst still reads the buffer.
    text_busy_next = text_busy;
    if (push && push_job.kind == JOB_TEXT) begin
      text_busy_next = 1'b1;
    end else if (text_done) begin
      text_busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_IDLE;
      sum       <= 8'd0;
      text_busy <= 1'b0;
    end else begin
      pos       <= pos_next;
      sum       <= sum_next;
      text_busy <= text_busy_next;
    end
    cmd <= cmd_next;
    d1  <= d1_next;
    d2  <= d2_next;
  end

endmodule
`default_nettype wire

[hw/rtl/pbfp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module pbfp_queue
  import pbfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == QCNT_W'(0));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pbfp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module pbfp_back
  import pbfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              empty,
  input  job_t                   head,
  output logic                   pop,
  output logic                   text_done,
  output logic                   ram_re,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  wire logic [7:0]        ram_rdata,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output result_t                out_res
);

  back_state_t       state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [7:0]        len, len_next;
  logic              out_valid_next;
  result_t           res_next;
  logic              load;
  logic              out_free;
  logic              is_last;

  assign out_free  = !out_valid || out_ready;
  assign is_last   = (9'(idx) == ({1'b0, len} + 9'd1));
  assign ram_raddr = idx;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    len_next   = len;
    pop        = 1'b0;
    text_done  = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    res_next   = '0;

    case (state)
      BK_IDLE: begin
        if (!empty && out_free) begin
          pop = 1'b1;
          if (head.kind == JOB_LED) begin
            load                   = 1'b1;
            res_next.msg_kind      = MSG_LED;
            res_next.led_word      = head.led_word;
            res_next.last_of_frame = 1'b1;
          end else if (head.len == 8'd0) begin
            load                   = 1'b1;
            text_done              = 1'b1;
            res_next.msg_kind      = MSG_TEXT;
            res_next.last_of_frame = 1'b1;
          end else begin
            // text bytes sit at buffer positions 2 .. len+1
            idx_next   = ADDR_W'(2);
            len_next   = head.len;
            state_next = BK_READ;
          end
        end
      end
      BK_READ: begin
        ram_re     = 1'b1;
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          load                   = 1'b1;
          res_next.msg_kind      = MSG_TEXT;
          res_next.text_byte     = ram_rdata;
          res_next.text_valid    = 1'b1;
          res_next.last_of_frame = is_last;
          if (is_last) begin
            text_done  = 1'b1;
            state_next = BK_IDLE;
          end else begin
            idx_next   = idx + ADDR_W'(1);
            state_next = BK_READ;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    idx <= idx_next;
    len <= len_next;
    if (load) begin
      out_res <= res_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/panel_bus_frame_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// Frame parser for a 9-bit panel bus. Each request on the slave side is one bus
// word: s_tuser is the start mark and s_tdata the data byte. A marked word opens
// a frame and carries its command byte. An LED frame (command = LED code) is two
// data bytes and a checksum and yields one result holding a 16-bit LED word. A
// text frame (command = text code) is a length byte L, L text bytes and a
// checksum and yields L results, one text byte each, or a single empty result
// when L is zero. The checksum is the 8-bit wrapping sum of all earlier bytes
// of the frame. Bad checksums, unknown commands and frames longer than the
// 32-byte buffer are dropped without any result; words before the first start
// mark are ignored. If both codes are equal the frame parses as an LED frame.
// Timing: the front end takes one word per cycle while the job queue has room
// and no text replay runs. A valid LED frame is handed to the output register
// through a two-entry job queue. A valid text frame of L bytes is replayed
// from the frame buffer RAM, one read and one output load per byte; the input
// stalls from its checksum word until its last byte is loaded, which master
// side backpressure delays. The frame buffer needs no clearing after reset.
// Write the code registers only while the block is idle.
module panel_bus_frame_parser
  import pbfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // slave side: one bus word per request
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
  input  wire logic                 s_tuser,   // [0] start_mark
  // master side: one result per request
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [23:0]               m_tdata,   // [15:0] led_word, [23:16] text_byte
  output logic [1:0]                m_tuser,   // [0] msg_kind, [1] text_valid
  output logic                      m_tlast,   // last_of_frame
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [7:0]           cfg_wdata
);

  logic [7:0]        led_code;
  logic [7:0]        text_code;

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  job_t              q_in;
  job_t              q_head;
  logic              text_done;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  result_t           res;

  // Command code registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      led_code  <= LED_CODE_RST;
      text_code <= TEXT_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LED_CODE:  led_code  <= cfg_wdata;
        CFG_TEXT_CODE: text_code <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Front: track the frame, store bytes, post a job on a good checksum.
  pbfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .start_mark(s_tuser),
    .rx_byte   (s_tdata),
    .led_code  (led_code),
    .text_code (text_code),
    .q_full    (q_full),
    .push      (q_push),
    .push_job  (q_in),
    .text_done (text_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  // Frame buffer; only text bytes are ever read back.
  pbfp_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_LEN)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Jobs between front and back.
  pbfp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_in),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  // Back: turn each job into results, replaying text from the buffer.
  pbfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .head     (q_head),
    .pop      (q_pop),
    .text_done(text_done),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (res)
  );

  // Pack the result onto the master side.
  assign m_tdata = {res.text_byte, res.led_word};
  assign m_tuser = {res.text_valid, res.msg_kind};
  assign m_tlast = res.last_of_frame;

endmodule
`default_nettype wire

[bench/panel_bus_frame_checker.sv]
`timescale 1ns / 1ps
module panel_bus_frame_checker
  import pbfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] rx_byte
  input  logic                 s_tuser,   // [0] start_mark
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [23:0]          m_tdata,   // [15:0] led_word, [23:16] text_byte
  input  logic [1:0]           m_tuser,   // [0] msg_kind, [1] text_valid
  input  logic                 m_tlast,   // last_of_frame
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]           cfg_wdata,
  output int                   errors,
  output int                   pending
);

  // Shadow of the parser: frame bytes, fill position, running sum, codes.
  logic [7:0] frame_bytes [MAX_FRAME_LEN];
  int         fill_pos;
  logic [7:0] byte_sum;
  logic [7:0] led_code;
  logic [7:0] text_code;
  result_t    due_results [$];
  int         fails;

  initial begin
    fails = 0;
  end

  function automatic void keep_byte(input logic [7:0] b);
    if (fill_pos < MAX_FRAME_LEN) begin
      frame_bytes[fill_pos] = b;
      byte_sum = byte_sum + b;
      fill_pos++;
    end
  endfunction

  function automatic void queue_result(input logic kind, input logic [15:0] led,
                                       input logic [7:0] ch, input logic chv,
                                       input logic last);
    result_t r;
    r.msg_kind      = kind;
    r.led_word      = led;
    r.text_byte     = ch;
    r.text_valid    = chv;
    r.last_of_frame = last;
    due_results.push_back(r);
  endfunction

  // Advance the shadow by one bus word and queue whatever results it releases.
  function automatic void parse_bus_word(input logic mark, input logic [7:0] b);
    int len;
    if (mark) begin
      frame_bytes[0] = b;
      byte_sum       = b;
      fill_pos       = 1;
      return;
    end
    if (fill_pos >= MAX_FRAME_LEN) return;
    if (frame_bytes[0] == led_code) begin
      if (fill_pos < 3) begin
        keep_byte(b);
      end else if (fill_pos == 3) begin
        if (byte_sum == b) queue_result(MSG_LED, {frame_bytes[2], frame_bytes[1]}, 8'h00,
                                        1'b0, 1'b1);
        fill_pos++;
      end
    end else if (frame_bytes[0] == text_code) begin
      len = (fill_pos > 1) ? int'(frame_bytes[1]) : 0;
      if (fill_pos == 1 || fill_pos < len + 2) begin
        keep_byte(b);
      end else if (fill_pos == len + 2) begin
        if (byte_sum == b) begin
          if (len == 0) begin
            queue_result(MSG_TEXT, 16'h0000, 8'h00, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < len && i + 2 < MAX_FRAME_LEN; i++)
              queue_result(MSG_TEXT, 16'h0000, frame_bytes[i + 2], 1'b1, i + 1 == len);
          end
        end
        fill_pos++;
      end
    end
  endfunction

  function automatic bit same_field(input string what, input logic [15:0] want,
                                    input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    bit      ok;
    if (rst) begin
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      fill_pos  = MAX_FRAME_LEN;
      byte_sum  = 8'h00;
      led_code  = LED_CODE_RST;
      text_code = TEXT_CODE_RST;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LED_CODE:  led_code  = cfg_wdata;
          CFG_TEXT_CODE: text_code = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) parse_bus_word(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h/%h/%b", $time,
                   m_tdata, m_tuser, m_tlast);
          fails++;
        end else begin
          want = due_results.pop_front();
          ok = 1'b1;
          ok &= same_field("msg_kind", want.msg_kind, m_tuser[0]);
          ok &= same_field("led_word", want.led_word, m_tdata[15:0]);
          ok &= same_field("text_byte", want.text_byte, m_tdata[23:16]);
          ok &= same_field("text_valid", want.text_valid, m_tuser[1]);
          ok &= same_field("last_of_frame", want.last_of_frame, m_tlast);
          if (!ok) fails++;
        end
      end
    end
    errors  <= fails;
    pending <= due_results.size();
  end

endmodule

[bench/tb_panel_bus_frame_parser.sv]
`timescale 1ns / 1ps
module tb_panel_bus_frame_parser;
  import pbfp_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [23:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [7:0]           cfg_wdata;

  int fail_count;
  int results_due;

  // Stimulus bookkeeping: the codes currently loaded, the number of bus words
  // sent, and whether random idling is switched off for the closing phase.
  logic [7:0] led_code_now;
  logic [7:0] text_code_now;
  int         words_sent;
  bit         quiet;

  panel_bus_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  panel_bus_frame_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .errors   (fail_count),
    .pending  (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, even with every text frame at
  // its longest and both sides stalling at their worst.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: hold tready low for random bursts, never in the quiet phase.
  // Raise and lower on different edges only.
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offer one bus word, optionally after an idle burst, and hold it until the
  // request is taken.
  task automatic put_word(input logic mark, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mark;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Send a whole frame: marked command, body, then the checksum. A bad frame
  // gets its checksum flipped by a nonzero pattern so it can never match.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] body [$],
                            input bit bad);
    logic [7:0] sum;
    sum = cmd;
    put_word(1'b1, cmd);
    foreach (body[i]) begin
      put_word(1'b0, body[i]);
      sum = sum + body[i];
    end
    if (bad) sum = sum ^ 8'($urandom_range(1, 255));
    put_word(1'b0, sum);
  endtask

  // Write one code register; drop the enable on the following edge so back to
  // back writes never touch cfg_we twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Let every predicted result come out, then give the block time to finish
  // any frame that releases nothing.
  task automatic drain();
    int waited;
    s_tvalid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (results_due != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; the rest are bad checksums,
  // unknown commands, cut-off text frames and loose data words. An opener
  // always begins with a start mark so that a code change never meets a frame
  // left open from the previous setting.
  task automatic random_frame(input bit opener);
    logic [7:0] body [$];
    int         pick;
    int         len;
    int         tier;
    pick = opener ? $urandom_range(0, 17) : $urandom_range(0, 19);
    if (pick < 8) begin
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      send_frame(led_code_now, body, $urandom_range(0, 7) == 0);
    end else if (pick < 16) begin
      // Mostly short texts, some long, a few too long for the buffer.
      tier = $urandom_range(0, 19);
      if (tier < 14)      len = $urandom_range(0, 6);
      else if (tier < 18) len = $urandom_range(7, 29);
      else                len = $urandom_range(30, 40);
      body.push_back(8'(len));
      repeat (len) body.push_back(8'($urandom));
      send_frame(text_code_now, body, $urandom_range(0, 7) == 0);
    end else if (pick < 18) begin
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
      send_frame(8'($urandom), body, $urandom_range(0, 3) == 0);
    end else if (pick == 18) begin
      repeat ($urandom_range(1, 4)) put_word(1'b0, 8'($urandom));
    end else begin
      // Text frame cut short by the next start mark.
      put_word(1'b1, text_code_now);
      put_word(1'b0, 8'($urandom_range(4, 20)));
      repeat ($urandom_range(0, 3)) put_word(1'b0, 8'($urandom));
    end
    // Occasionally trail one more data word; after a checksum it must be ignored.
    if ($urandom_range(0, 9) == 0) put_word(1'b0, 8'($urandom));
  endtask

  initial begin
    int goal;
    s_tvalid      <= 1'b0;
    s_tuser       <= 1'b0;
    s_tdata       <= 8'h00;
    cfg_we        <= 1'b0;
    cfg_addr      <= CFG_LED_CODE;
    cfg_wdata     <= 8'h00;
    rst           <= 1'b1;
    quiet         = 1'b0;
    words_sent    = 0;
    led_code_now  = LED_CODE_RST;
    text_code_now = TEXT_CODE_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, on the reset codes.
    // Data words before any start mark: ignore.
    put_word(1'b0, 8'h00);
    put_word(1'b0, 8'hFF);
    put_word(1'b0, LED_CODE_RST);
    // LED frame with extreme data bytes, then a stray word after the checksum.
    send_frame(LED_CODE_RST, '{8'h00, 8'hFF}, 1'b0);
    put_word(1'b0, 8'hAA);
    // LED frame with a bad checksum: drop.
    send_frame(LED_CODE_RST, '{8'hFF, 8'hFF}, 1'b1);
    // Unknown commands swallow data until the next start mark.
    put_word(1'b1, 8'h00);
    put_word(1'b0, 8'h12);
    put_word(1'b1, 8'hFF);
    // Empty text frame: one empty result.
    send_frame(TEXT_CODE_RST, '{8'h00}, 1'b0);
    // Text with a zero byte and an all-ones byte, passed through raw.
    send_frame(TEXT_CODE_RST, '{8'h03, 8'h00, 8'hFF, 8'h41}, 1'b0);
    // Text with a bad checksum: drop.
    send_frame(TEXT_CODE_RST, '{8'h01, 8'h7E}, 1'b1);
    drain();

    // Random phases: extreme codes both ways, equal codes, random codes, and
    // back to the reset codes for a closing phase with no idling at all.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin led_code_now = 8'h00; text_code_now = 8'hFF; end
        1: begin led_code_now = 8'hFF; text_code_now = 8'h00; end
        2: begin led_code_now = 8'hA5; text_code_now = 8'hA5; end
        3: begin led_code_now = 8'($urandom); text_code_now = 8'($urandom); end
        default: begin led_code_now = LED_CODE_RST; text_code_now = TEXT_CODE_RST; end
      endcase
      write_reg(CFG_LED_CODE, led_code_now);
      write_reg(CFG_TEXT_CODE, text_code_now);
      quiet = (ph == 4);
      goal = words_sent + 70;
      random_frame(1'b1);
      while (words_sent < goal) random_frame(1'b0);
      drain();
    end

    if (results_due != 0)
      $display("%0t: %0d expected results never arrived", $time, results_due);
    if (fail_count == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pbfp_pkg.sv
hw/rtl/pbfp_ram.sv
hw/rtl/pbfp_front.sv
hw/rtl/pbfp_queue.sv
hw/rtl/pbfp_back.sv
hw/rtl/panel_bus_frame_parser.sv
bench/panel_bus_frame_checker.sv
bench/tb_panel_bus_frame_parser.sv
